// ===== rtl/core/mbfdc_pkg.sv =====
// Shared types and codes for the multi-buffer fill/drain controller.
package mbfdc_pkg;

    localparam int DATA_W  = 32;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_SWITCHED = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_DROPPED  = 2'd3;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [IDX_W-1:0]  buffer_index;
        logic [STAT_W-1:0] status;
    } result_t;

endpackage

// ===== rtl/core/mbfdc_if.sv =====
// Request and response channel interfaces of the fill/drain controller.
interface mbfdc_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [mbfdc_pkg::DATA_W-1:0] write_value;

    modport source (output valid, output operation, output write_value, input ready);
    modport sink   (input valid, input operation, input write_value, output ready);
endinterface

interface mbfdc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          read_valid;
    logic [mbfdc_pkg::DATA_W-1:0]  read_data;
    logic                          last_of_buffer;
    logic [mbfdc_pkg::IDX_W-1:0]   buffer_index;
    logic [mbfdc_pkg::STAT_W-1:0]  status;

    modport source (output valid, output read_valid, output read_data,
                    output last_of_buffer, output buffer_index, output status,
                    input ready);
    modport sink   (input valid, input read_valid, input read_data,
                    input last_of_buffer, input buffer_index, input status,
                    output ready);
endinterface

// ===== rtl/core/mbfdc_store.sv =====
// Word store for all buffers: one access per cycle, registered read data.
module mbfdc_store #(
    parameter int WORD_WIDTH = 32,
    parameter int ADDR_W     = 12,
    parameter int DEPTH      = 4096
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [WORD_WIDTH-1:0] wdata,
    output logic [WORD_WIDTH-1:0] rd_data
);

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mbfdc_ring_ctrl.sv =====
// Buffer ring bookkeeping: fill, completion search, drain selection, store access.
module mbfdc_ring_ctrl #(
    parameter int NUM_BUFFERS  = 4,
    parameter int BUFFER_DEPTH = 1024,
    parameter int WORD_WIDTH   = 32,
    parameter int ADDR_W       = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mbfdc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                              accept,
    input  logic                              operation,
    input  logic [mbfdc_pkg::DATA_W-1:0]      write_value,
    output mbfdc_pkg::result_t                res_next,
    output logic                              mem_wr_en,
    output logic                              mem_rd_en,
    output logic [ADDR_W-1:0]                 mem_addr,
    output logic [WORD_WIDTH-1:0]             mem_wdata
);

    localparam int BUF_W = $clog2(NUM_BUFFERS);
    localparam int OFF_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int LIM_W = (CNT_W > mbfdc_pkg::CFG_W) ? CNT_W : mbfdc_pkg::CFG_W;
    localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(BUFFER_DEPTH);
    localparam logic [LIM_W-1:0] LIM_RST = (BUFFER_DEPTH < 1024) ? LIM_W'(BUFFER_DEPTH)
                                                                 : LIM_W'(1024);

    logic [LIM_W-1:0]       lim_reg;
    logic [LIM_W-1:0]       lim_next;
    logic [NUM_BUFFERS-1:0] full_reg, full_next;
    logic [BUF_W-1:0]       active_reg, active_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [BUF_W-1:0]       drain_reg, drain_next;
    logic [OFF_W-1:0]       offset_reg, offset_next;
    logic                   overflow_reg, overflow_next;

    function automatic logic [BUF_W-1:0] ring_add(input logic [BUF_W-1:0] base,
                                                  input logic [BUF_W:0] step);
        logic [BUF_W:0] sum;
        sum = {1'b0, base} + step;
        if (sum >= (BUF_W+1)'(NUM_BUFFERS))
        begin
            sum = sum - (BUF_W+1)'(NUM_BUFFERS);
        end
        return sum[BUF_W-1:0];
    endfunction

    // Clamp the written limit to one word up to a whole buffer.
    always_comb
    begin
        logic [LIM_W-1:0] ext;
        ext = LIM_W'(cfg_data);
        if (ext == '0)
        begin
            lim_next = LIM_W'(1);
        end
        else if (ext > LIM_MAX)
        begin
            lim_next = LIM_MAX;
        end
        else
        begin
            lim_next = ext;
        end
    end

    // Next empty buffer after the active one, and first full one from the drain pointer.
    logic             empty_found;
    logic [BUF_W-1:0] empty_sel;
    logic             full_found;
    logic [BUF_W-1:0] full_sel;

    always_comb
    begin
        logic [BUF_W-1:0] cand;
        empty_found = 1'b0;
        empty_sel   = active_reg;
        full_found  = 1'b0;
        full_sel    = drain_reg;
        for (int k = 0; k < NUM_BUFFERS; k++)
        begin
            cand = ring_add(active_reg, (BUF_W+1)'(k));
            if (k != 0 && !empty_found && !full_reg[cand])
            begin
                empty_found = 1'b1;
                empty_sel   = cand;
            end
            cand = ring_add(drain_reg, (BUF_W+1)'(k));
            if (!full_found && full_reg[cand])
            begin
                full_found = 1'b1;
                full_sel   = cand;
            end
        end
    end

    always_comb
    begin
        logic [CNT_W-1:0] cnt_inc;
        logic             room;
        logic [OFF_W-1:0] rd_off;
        full_next     = full_reg;
        active_next   = active_reg;
        fill_next     = fill_reg;
        drain_next    = drain_reg;
        offset_next   = offset_reg;
        overflow_next = overflow_reg;
        res_next      = '0;
        mem_wr_en     = 1'b0;
        mem_rd_en     = 1'b0;
        mem_addr      = '0;
        mem_wdata     = WORD_WIDTH'(write_value);
        room          = fill_reg < CNT_W'(BUFFER_DEPTH);
        cnt_inc       = room ? fill_reg + CNT_W'(1) : fill_reg;
        rd_off        = (full_sel != drain_reg) ? '0 : offset_reg;

        if (operation == mbfdc_pkg::OP_PUSH)
        begin
            res_next.buffer_index = mbfdc_pkg::IDX_W'(active_reg);
            mem_addr = ADDR_W'(active_reg) * ADDR_W'(BUFFER_DEPTH)
                     + ADDR_W'(fill_reg[OFF_W-1:0]);
            if (overflow_reg)
            begin
                res_next.status = mbfdc_pkg::STATUS_DROPPED;
            end
            else
            begin
                mem_wr_en = accept && room;
                fill_next = cnt_inc;
                if (LIM_W'(cnt_inc) >= lim_reg)
                begin
                    if (empty_found)
                    begin
                        full_next[active_reg] = 1'b1;
                        active_next = empty_sel;
                        fill_next   = '0;
                        res_next.status = mbfdc_pkg::STATUS_SWITCHED;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                        res_next.status = mbfdc_pkg::STATUS_OVERFLOW;
                    end
                end
            end
        end
        else
        begin
            res_next.buffer_index = mbfdc_pkg::IDX_W'(full_sel);
            mem_addr = ADDR_W'(full_sel) * ADDR_W'(BUFFER_DEPTH) + ADDR_W'(rd_off);
            if (full_found)
            begin
                mem_rd_en      = accept;
                res_next.valid = 1'b1;
                drain_next     = full_sel;
                if ((LIM_W+1)'(rd_off) + (LIM_W+1)'(1) >= (LIM_W+1)'(lim_reg))
                begin
                    res_next.last = 1'b1;
                    full_next[full_sel] = 1'b0;
                    offset_next = '0;
                    drain_next  = ring_add(full_sel, (BUF_W+1)'(1));
                end
                else
                begin
                    offset_next = rd_off + OFF_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg      <= LIM_RST;
            full_reg     <= '0;
            active_reg   <= '0;
            fill_reg     <= '0;
            drain_reg    <= '0;
            offset_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                lim_reg <= lim_next;
            end
            if (accept)
            begin
                full_reg     <= full_next;
                active_reg   <= active_next;
                fill_reg     <= fill_next;
                drain_reg    <= drain_next;
                offset_reg   <= offset_next;
                overflow_reg <= overflow_next;
            end
        end
    end

`ifndef SYNTHESIS
    // Overflow holds until reset.
    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared without reset");

    // The buffer being filled is never marked full.
    a_active_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        !full_reg[active_reg])
        else $error("active buffer marked full");

    // Fill count never passes the buffer depth.
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(BUFFER_DEPTH))
        else $error("fill count beyond buffer depth");

    // A dropped push never touches the store.
    a_drop_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && overflow_reg && operation == mbfdc_pkg::OP_PUSH) |-> !mem_wr_en)
        else $error("dropped push wrote the store");
`endif

endmodule

// ===== rtl/core/multi_buffer_fill_drain_controller.sv =====
// Top level of the multi-buffer fill/drain controller.
//
// Requests arrive on cmd (valid/ready): operation 0 pushes write_value into
// the active buffer, operation 1 reads one word of the next full buffer.
// Every accepted request gives exactly one response on rsp (valid/ready)
// carrying read_valid, read_data, last_of_buffer, buffer_index and status.
// The fill limit is written through cfg_we/cfg_data; the user must do so only
// while the block is idle, which the block does not enforce. Zero acts as one
// and values above the buffer depth act as the depth. Throughput is one
// request per cycle unless rsp stalls: the ring search and the single store
// port are used once per request, and the response register frees the request
// side. When rsp stalls, the response holds and cmd.ready drops until it is
// taken; a new request is taken in the same cycle the held response leaves.
// Reset clears all full marks, pointers, the fill count and the overflow
// flag and sets the limit to 1024 words, bounded by the buffer depth; the
// store contents are left as they are and need no clearing pass.
module multi_buffer_fill_drain_controller #(
    parameter int NUM_BUFFERS  = 4,
    parameter int BUFFER_DEPTH = 1024,
    parameter int WORD_WIDTH   = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mbfdc_pkg::CFG_W-1:0] cfg_data,
    mbfdc_cmd_if.sink                   cmd,
    mbfdc_rsp_if.source                 rsp
);

    localparam int STORE_DEPTH = NUM_BUFFERS * BUFFER_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic                  accept;
    mbfdc_pkg::result_t    res_next;
    mbfdc_pkg::result_t    res_reg;
    logic                  out_valid_reg;
    logic                  mem_wr_en;
    logic                  mem_rd_en;
    logic [ADDR_W-1:0]     mem_addr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic [WORD_WIDTH-1:0] rd_word;

    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    mbfdc_ring_ctrl #(
        .NUM_BUFFERS  (NUM_BUFFERS),
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .WORD_WIDTH   (WORD_WIDTH),
        .ADDR_W       (ADDR_W)
    ) u_ring_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .operation   (cmd.operation),
        .write_value (cmd.write_value),
        .res_next    (res_next),
        .mem_wr_en   (mem_wr_en),
        .mem_rd_en   (mem_rd_en),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata)
    );

    mbfdc_store #(
        .WORD_WIDTH (WORD_WIDTH),
        .ADDR_W     (ADDR_W),
        .DEPTH      (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wdata   (mem_wdata),
        .rd_data (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            out_valid_reg <= cmd.valid;
        end
    end

    // Hold the response fields while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_valid     = res_reg.valid;
    assign rsp.read_data      = res_reg.valid ? mbfdc_pkg::DATA_W'(rd_word) : '0;
    assign rsp.last_of_buffer = res_reg.last;
    assign rsp.buffer_index   = res_reg.buffer_index;
    assign rsp.status         = res_reg.status;

endmodule

// ===== tb/sv/multi_buffer_fill_drain_controller_tb.sv =====
// Testbench for the multi-buffer fill/drain controller: random and directed requests, scoreboard.
`timescale 1ns / 100ps

module multi_buffer_fill_drain_controller_tb;

    localparam int NUM_BUF     = 4;
    localparam int BUF_DEPTH   = 1024;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                         read_valid;
        logic [mbfdc_pkg::DATA_W-1:0] read_data;
        logic                         last_of_buffer;
        logic [mbfdc_pkg::IDX_W-1:0]  buffer_index;
        logic [mbfdc_pkg::STAT_W-1:0] status;
    } ring_response_t;

    // Ring of buffers as seen from the ports, plus the responses still owed.
    class buffer_ring_model;
        logic [mbfdc_pkg::DATA_W-1:0] store [NUM_BUF*BUF_DEPTH];
        int                           written_depth [NUM_BUF];
        logic [NUM_BUF-1:0]           full_marks;
        int                           fill_buffer;
        int                           fill_count;
        int                           drain_pointer;
        int                           read_offset;
        bit                           overflow;
        logic [mbfdc_pkg::CFG_W-1:0]  limit_reg;
        ring_response_t               expected_responses [$];
        int                           mismatches;

        function new();
            for (int b = 0; b < NUM_BUF; b++)
                written_depth[b] = 0;
            full_marks    = '0;
            fill_buffer   = 0;
            fill_count    = 0;
            drain_pointer = 0;
            read_offset   = 0;
            overflow      = 1'b0;
            limit_reg     = 11'd1024;
            mismatches    = 0;
        endfunction

        function int eff_limit();
            int lim;
            lim = limit_reg;
            if (lim < 1)
                lim = 1;
            if (lim > BUF_DEPTH)
                lim = BUF_DEPTH;
            return lim;
        endfunction

        // Keep a raised limit within the words already written to any waiting buffer.
        function logic [mbfdc_pkg::CFG_W-1:0] safe_limit(logic [mbfdc_pkg::CFG_W-1:0] req);
            int lim;
            int capped;
            lim = req;
            if (lim < 1)
                lim = 1;
            if (lim > BUF_DEPTH)
                lim = BUF_DEPTH;
            capped = lim;
            for (int b = 0; b < NUM_BUF; b++)
                if (full_marks[b] && written_depth[b] < capped)
                    capped = written_depth[b];
            return (capped == lim) ? req : capped[mbfdc_pkg::CFG_W-1:0];
        endfunction

        function bit push_would_overflow();
            int cnt;
            if (overflow)
                return 1'b0;
            cnt = fill_count + ((fill_count < BUF_DEPTH) ? 1 : 0);
            if (cnt < eff_limit())
                return 1'b0;
            for (int k = 1; k < NUM_BUF; k++)
                if (!full_marks[(fill_buffer + k) % NUM_BUF])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_request(logic op, logic [mbfdc_pkg::DATA_W-1:0] wval);
            ring_response_t rsp;
            int lim;
            int sel;
            int c;
            bit found;
            rsp = '0;
            lim = eff_limit();
            if (op == mbfdc_pkg::OP_PUSH)
            begin
                rsp.buffer_index = fill_buffer[mbfdc_pkg::IDX_W-1:0];
                rsp.status = mbfdc_pkg::STATUS_OK;
                if (overflow)
                begin
                    rsp.status = mbfdc_pkg::STATUS_DROPPED;
                end
                else
                begin
                    if (fill_count < BUF_DEPTH)
                    begin
                        store[fill_buffer*BUF_DEPTH + fill_count] = wval;
                        fill_count++;
                        if (written_depth[fill_buffer] < fill_count)
                            written_depth[fill_buffer] = fill_count;
                    end
                    if (fill_count >= lim)
                    begin
                        found = 1'b0;
                        sel = fill_buffer;
                        for (int k = 1; k < NUM_BUF && !found; k++)
                        begin
                            c = (fill_buffer + k) % NUM_BUF;
                            if (!full_marks[c])
                            begin
                                sel = c;
                                found = 1'b1;
                            end
                        end
                        if (found)
                        begin
                            full_marks[fill_buffer] = 1'b1;
                            fill_buffer = sel;
                            fill_count = 0;
                            rsp.status = mbfdc_pkg::STATUS_SWITCHED;
                        end
                        else
                        begin
                            overflow = 1'b1;
                            rsp.status = mbfdc_pkg::STATUS_OVERFLOW;
                        end
                    end
                end
            end
            else
            begin
                rsp.buffer_index = drain_pointer[mbfdc_pkg::IDX_W-1:0];
                rsp.status = mbfdc_pkg::STATUS_OK;
                found = 1'b0;
                sel = drain_pointer;
                for (int k = 0; k < NUM_BUF && !found; k++)
                begin
                    c = (drain_pointer + k) % NUM_BUF;
                    if (full_marks[c])
                    begin
                        sel = c;
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    if (sel != drain_pointer)
                        read_offset = 0;
                    drain_pointer = sel;
                    rsp.read_valid = 1'b1;
                    rsp.buffer_index = sel[mbfdc_pkg::IDX_W-1:0];
                    rsp.read_data = store[sel*BUF_DEPTH + read_offset];
                    if (read_offset + 1 >= lim)
                    begin
                        rsp.last_of_buffer = 1'b1;
                        full_marks[sel] = 1'b0;
                        read_offset = 0;
                        drain_pointer = (sel + 1) % NUM_BUF;
                    end
                    else
                    begin
                        read_offset++;
                    end
                end
            end
            expected_responses.push_back(rsp);
        endfunction

        function void check_response(ring_response_t got);
            ring_response_t exp_rsp;
            if (expected_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected response: valid=%0d data=%08h last=%0d buf=%0d %s%0d",
                             got.read_valid, got.read_data, got.last_of_buffer,
                             got.buffer_index, "status=", got.status);
                return;
            end
            exp_rsp = expected_responses.pop_front();
            if (got.read_valid !== exp_rsp.read_valid ||
                got.read_data !== exp_rsp.read_data ||
                got.last_of_buffer !== exp_rsp.last_of_buffer ||
                got.buffer_index !== exp_rsp.buffer_index || got.status !== exp_rsp.status)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("mismatch: expected valid=%0d data=%08h last=%0d buf=%0d status=%0d",
                             exp_rsp.read_valid, exp_rsp.read_data, exp_rsp.last_of_buffer,
                             exp_rsp.buffer_index, exp_rsp.status);
                    $display("          got      valid=%0d data=%08h last=%0d buf=%0d status=%0d",
                             got.read_valid, got.read_data, got.last_of_buffer,
                             got.buffer_index, got.status);
                end
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we;
    logic [mbfdc_pkg::CFG_W-1:0] cfg_data;
    int                          cycle_count = 0;
    bit                          calm_stretch = 1'b0;
    buffer_ring_model            ring;
    ring_response_t              observed;

    mbfdc_cmd_if cmd_ch ();
    mbfdc_rsp_if rsp_ch ();

    multi_buffer_fill_drain_controller uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd_ch),
        .rsp      (rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multi_buffer_fill_drain_controller_tb NOT OK");
            $finish;
        end
    end

    // Check the response before noting the request so a stray response is never matched late.
    always @(posedge clk)
    begin
        if (rst_n && ring != null)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                observed.read_valid     = rsp_ch.read_valid;
                observed.read_data      = rsp_ch.read_data;
                observed.last_of_buffer = rsp_ch.last_of_buffer;
                observed.buffer_index   = rsp_ch.buffer_index;
                observed.status         = rsp_ch.status;
                ring.check_response(observed);
            end
            if (cmd_ch.valid && cmd_ch.ready)
                ring.note_request(cmd_ch.operation, cmd_ch.write_value);
        end
    end

    // Response side: stall a random number of cycles before taking each response.
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = calm_stretch ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic op, input logic [mbfdc_pkg::DATA_W-1:0] wval);
        int gap;
        gap = calm_stretch ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.operation   <= op;
        cmd_ch.write_value <= wval;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    // Push unless that push would overflow the ring; read instead then.
    task automatic push_or_read(input logic [mbfdc_pkg::DATA_W-1:0] wval);
        if (ring.push_would_overflow())
            send_request(mbfdc_pkg::OP_READ, wval);
        else
            send_request(mbfdc_pkg::OP_PUSH, wval);
    endtask

    task automatic write_limit(input logic [mbfdc_pkg::CFG_W-1:0] req);
        logic [mbfdc_pkg::CFG_W-1:0] value;
        cmd_ch.valid <= 1'b0;
        while (ring.expected_responses.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
        value = ring.safe_limit(req);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        ring.limit_reg = value;
    endtask

    task automatic drain_all();
        while (ring.full_marks != '0)
            send_request(mbfdc_pkg::OP_READ, $urandom);
    endtask

    task automatic run_random(input int count, input int push_pct);
        logic [mbfdc_pkg::DATA_W-1:0] wval;
        for (int i = 0; i < count; i++)
        begin
            if (i % 32 == 0)
                calm_stretch = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:       wval = '0;
                1:       wval = '1;
                default: wval = $urandom;
            endcase
            if ($urandom_range(0, 99) < push_pct)
                push_or_read(wval);
            else
                send_request(mbfdc_pkg::OP_READ, wval);
        end
        calm_stretch = 1'b0;
    endtask

    initial
    begin
        cfg_we             = 1'b0;
        cfg_data           = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.operation   = mbfdc_pkg::OP_PUSH;
        cmd_ch.write_value = '0;
        ring = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset limit: read with nothing full, then a partial fill.
        send_request(mbfdc_pkg::OP_READ, 32'hFFFF_FFFF);
        push_or_read(32'h0000_0000);
        push_or_read(32'hFFFF_FFFF);
        push_or_read(32'h5A5A_5A5A);
        // Lower the limit below the fill count: next push completes the buffer.
        write_limit(11'd2);
        push_or_read(32'h8000_0001);
        send_request(mbfdc_pkg::OP_READ, 32'h0);
        send_request(mbfdc_pkg::OP_READ, 32'h0);
        send_request(mbfdc_pkg::OP_READ, 32'h0);
        push_or_read(32'h0000_0001);
        push_or_read(32'h0000_0002);
        // Lower the limit while a full buffer waits: drain it with the new limit.
        write_limit(11'd1);
        send_request(mbfdc_pkg::OP_READ, 32'h0);
        // Zero acts as one: every push completes a buffer.
        write_limit(11'd0);
        push_or_read(32'h1234_5678);
        push_or_read(32'h8765_4321);
        push_or_read(32'hDEAD_BEEF);
        send_request(mbfdc_pkg::OP_READ, 32'h0);
        send_request(mbfdc_pkg::OP_READ, 32'h0);
        send_request(mbfdc_pkg::OP_READ, 32'h0);
        send_request(mbfdc_pkg::OP_READ, 32'h0);

        // Above the depth acts as the depth: a partial fill stays open.
        write_limit(11'd2047);
        run_random(60, 70);
        drain_all();
        // Drop the limit below the open fill: the next push completes it.
        write_limit(11'd7);
        run_random(120, 55);
        write_limit(11'd1);
        run_random(60, 50);
        write_limit(11'd4);
        run_random(100, 60);
        write_limit(mbfdc_pkg::CFG_W'($urandom_range(1, 12)));
        run_random(80, 50);
        write_limit(11'd3);
        run_random(60, 50);

        // Overflow is sticky until reset, so it comes last.
        drain_all();
        write_limit(11'd2);
        while (!ring.overflow)
            send_request(mbfdc_pkg::OP_PUSH, $urandom);
        send_request(mbfdc_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_request(mbfdc_pkg::OP_PUSH, 32'h0);
        drain_all();
        send_request(mbfdc_pkg::OP_READ, 32'h0);
        send_request(mbfdc_pkg::OP_PUSH, $urandom);
        cmd_ch.valid <= 1'b0;

        while (ring.expected_responses.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (ring.mismatches == 0 && ring.expected_responses.size() == 0)
            $display("multi_buffer_fill_drain_controller_tb OK");
        else
            $display("multi_buffer_fill_drain_controller_tb NOT OK");
        $finish;
    end

endmodule
